[hdl/ptc_pkg.sv]
package ptc_pkg;

    // Field widths
    localparam int PRESS_W  = 17;
    localparam int TIME_W   = 32;
    localparam int INTV_W   = 22;
    localparam int MINS_W   = 7;
    localparam int WIN_W    = 27;
    localparam int THR_W    = 17;
    localparam int RATE_W   = 24;
    localparam int KIND_W   = 3;
    localparam int LABEL_W  = 2;
    localparam int BASIS_W  = 24;

    // Magnitude of pressure change times the rate basis
    localparam int NUM_W    = PRESS_W + BASIS_W;

    // Port widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 27;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // Three hours in milliseconds
    localparam logic [BASIS_W-1:0] RATE_BASIS_MS = 24'd10800000;

    localparam logic [PRESS_W-1:0] LOW_PRESSURE_PA  = 17'd95000;
    localparam logic [PRESS_W-1:0] HIGH_PRESSURE_PA = 17'd105000;
    localparam logic [THR_W-1:0]   STABLE_BAND_PA   = 17'd100;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;
    localparam logic [NUM_W-1:0] RATE_MAX_MAG = 41'd8388607;
    localparam logic [NUM_W-1:0] RATE_MIN_MAG = 41'd8388608;

    // Register reset values
    localparam logic [INTV_W-1:0] SAMPLE_INTERVAL_RST = 22'd300000;
    localparam logic [MINS_W-1:0] MIN_SAMPLES_RST     = 7'd2;
    localparam logic [WIN_W-1:0]  STABLE_WINDOW_RST   = 27'd10800000;
    localparam logic [THR_W-1:0]  RAPID_FALL_RST      = 17'd300;
    localparam logic [THR_W-1:0]  LARGE_CHANGE_RST    = 17'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_INTERVAL = 3'd0,
        CFG_MIN_SAMPLES     = 3'd1,
        CFG_STABLE_WINDOW   = 3'd2,
        CFG_RAPID_FALL      = 3'd3,
        CFG_LARGE_CHANGE    = 3'd4
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNKNOWN    = 3'd0,
        KIND_STABLE     = 3'd1,
        KIND_RISING     = 3'd2,
        KIND_FALLING    = 3'd3,
        KIND_LARGE_RISE = 3'd4,
        KIND_LARGE_FALL = 3'd5,
        KIND_RAPID_FALL = 3'd6
    } kind_t;

    typedef enum logic [LABEL_W-1:0] {
        LABEL_REFERENCE   = 2'd0,
        LABEL_ATTENTION   = 2'd1,
        LABEL_HIGH        = 2'd2,
        LABEL_UNAVAILABLE = 2'd3
    } label_t;

endpackage

[hdl/ptc_hist_mem.sv]
module ptc_hist_mem
    import ptc_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [PRESS_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [PRESS_W-1:0] rdata
);

    logic [PRESS_W-1:0] mem [DEPTH];
    logic [PRESS_W-1:0] rdata_reg;

    // Write one reading, read one with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ptc_divider.sv]
module ptc_divider
    import ptc_pkg::*;
#(
    parameter int DSOR_W = 29
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DSOR_W-1:0] divisor,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DSOR_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;

    logic [DSOR_W:0]   rem_sh;
    logic [DSOR_W:0]   rem_sub;
    logic              fits;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        fits    = (rem_sh >= {1'b0, divisor});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[DSOR_W-1:0] : rem_sh[DSOR_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/pressure_trend_classifier_core.sv]
// Barometric pressure tendency classifier. Each input item carries one reading
// (pressure in Pa, a valid flag and a free-running millisecond time); each item
// gives exactly one result: a seven-way trend kind, the rate in Pa per three
// hours (truncated toward zero, saturated to 24 bits) and a pressure label.
// Readings are kept in a single-port-write, registered-read history memory of
// HISTORY_DEPTH entries; the oldest stored reading is read back and compared
// with the current one. An item that yields a trend passes through the update,
// difference, multiply, compare, divide and finish steps before the next item
// can be taken; the divide step, in which the bit-serial divider yields 41
// quotient bits, scales the change to the three hour basis. An invalid reading
// or too few readings go straight to finish; a zero window skips the divide.
// The memory needs no clearing pass after reset. Configuration is taken on
// any cycle cfg_we is high and must only change while no item is in flight.
module pressure_trend_classifier_core
    import ptc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [16:0] pressure_pa, [48:17] now_ms, [55:49] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] pressure_valid
    input  logic [0:0]             s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [23:0] trend_rate, [25:24] pressure_label, [31:26] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] trend_kind
    output logic [KIND_W-1:0]      m_axis_tuser
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int OW    = AW + 1;
    localparam int W_W   = CW + INTV_W;
    localparam int TW_W  = W_W + THR_W;
    localparam int CMC_W = (CW > MINS_W) ? CW : MINS_W;
    localparam int EWC_W = (W_W > WIN_W) ? W_W : WIN_W;
    localparam int MGC_W = (TW_W > NUM_W) ? TW_W : NUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_DIV,
        S_FIN
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [INTV_W-1:0]  sample_interval_reg;
    logic [MINS_W-1:0]  min_samples_reg;
    logic [WIN_W-1:0]   stable_window_reg;
    logic [THR_W-1:0]   rapid_fall_reg;
    logic [THR_W-1:0]   large_change_reg;
    logic [AW-1:0]      ws_reg, ws_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TIME_W-1:0]  next_time_reg, next_time_next;
    logic               first_pending_reg, first_pending_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0]  m_tuser_reg;

    // Item datapath
    logic [PRESS_W-1:0] p_reg;
    logic               valid_in_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               enable_reg, enable_next;
    logic               fwd_reg, fwd_next;
    logic [PRESS_W-1:0] mag_reg;
    logic               pos_reg, neg_reg;
    logic [W_W-1:0]     w_reg;
    logic [NUM_W-1:0]   num_mag_reg;
    logic [TW_W-1:0]    tw_rapid_reg, tw_large_reg, tw_band_reg;
    logic               early_reg, wz_reg;
    logic               ge_rapid_reg, ge_large_reg, ge_band_reg;

    // Update stage
    logic [TIME_W-1:0]  elapsed;
    logic               store;
    logic [AW-1:0]      ws_new;
    logic [CW-1:0]      count_new;
    logic [OW-1:0]      oldest_sum;
    logic [OW-1:0]      oldest_wrap;
    logic [AW-1:0]      oldest_ix;

    // Difference stage
    logic [PRESS_W-1:0] old_p;
    logic [CW-1:0]      cnt_m1;

    // Memory and divider
    logic               mem_we;
    logic               mem_re;
    logic [PRESS_W-1:0] mem_rdata;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    // Result
    logic               fin_load;
    kind_t              kind;
    logic signed [RATE_W-1:0] rate;
    label_t             label;

    ptc_hist_mem #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ws_reg),
        .wdata (p_reg),
        .re    (mem_re),
        .raddr (oldest_ix),
        .rdata (mem_rdata)
    );

    ptc_divider #(
        .DSOR_W (W_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag_reg),
        .divisor  (w_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Decide storage and locate the oldest reading
    always_comb
    begin
        elapsed   = now_reg - next_time_reg;
        store     = valid_in_reg && (first_pending_reg || !elapsed[TIME_W-1]);
        ws_new    = ws_reg;
        count_new = count_reg;
        if (store)
        begin
            ws_new = (ws_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ws_reg + 1'b1;
            if (count_reg < CW'(HISTORY_DEPTH))
            begin
                count_new = count_reg + 1'b1;
            end
        end
        oldest_sum  = OW'(ws_new) + OW'(HISTORY_DEPTH) - OW'(count_new);
        oldest_wrap = oldest_sum - OW'(HISTORY_DEPTH);
        oldest_ix   = (oldest_sum >= OW'(HISTORY_DEPTH)) ? oldest_wrap[AW-1:0]
                                                        : oldest_sum[AW-1:0];
        enable_next = valid_in_reg && (count_new != '0)
                      && (CMC_W'(count_new) >= CMC_W'(min_samples_reg));
        // A single stored reading is the one written this cycle
        fwd_next    = store && (count_new == CW'(1));
    end

    // Next control state
    always_comb
    begin
        state_next         = state_reg;
        ws_next            = ws_reg;
        count_next         = count_reg;
        next_time_next     = next_time_reg;
        first_pending_next = first_pending_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        div_start          = 1'b0;
        fin_load           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                mem_re = 1'b1;
                if (store)
                begin
                    mem_we             = 1'b1;
                    ws_next            = ws_new;
                    count_next         = count_new;
                    next_time_next     = now_reg + TIME_W'(sample_interval_reg);
                    first_pending_next = 1'b0;
                end
                state_next = enable_next ? S_DIFF : S_FIN;
            end
            S_DIFF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                div_start  = !wz_reg;
                state_next = wz_reg ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    fin_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = fin_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    // Classify, scale and label the current item
    always_comb
    begin
        kind  = KIND_UNKNOWN;
        rate  = '0;
        label = LABEL_UNAVAILABLE;
        if (valid_in_reg)
        begin
            if (enable_reg)
            begin
                if (wz_reg && !pos_reg && !neg_reg)
                    kind = KIND_STABLE;
                else if (!early_reg && !pos_reg && ge_rapid_reg)
                    kind = KIND_RAPID_FALL;
                else if (!early_reg && !pos_reg && ge_large_reg)
                    kind = KIND_LARGE_FALL;
                else if (!early_reg && !neg_reg && ge_large_reg)
                    kind = KIND_LARGE_RISE;
                else if (!pos_reg && ge_band_reg)
                    kind = KIND_FALLING;
                else if (!neg_reg && ge_band_reg)
                    kind = KIND_RISING;
                else
                    kind = KIND_STABLE;

                if (wz_reg)
                begin
                    rate = pos_reg ? RATE_MAX : (neg_reg ? RATE_MIN : '0);
                end
                else if (neg_reg)
                begin
                    rate = (div_quo >= RATE_MIN_MAG) ? RATE_MIN
                                                     : RATE_W'(0) - div_quo[RATE_W-1:0];
                end
                else
                begin
                    rate = (div_quo > RATE_MAX_MAG) ? RATE_MAX : div_quo[RATE_W-1:0];
                end
            end

            label = LABEL_REFERENCE;
            if (p_reg < LOW_PRESSURE_PA || p_reg > HIGH_PRESSURE_PA)
                label = LABEL_ATTENTION;
            if (kind == KIND_RAPID_FALL)
                label = LABEL_HIGH;
            else if (kind == KIND_LARGE_RISE || kind == KIND_LARGE_FALL)
                label = LABEL_ATTENTION;
        end
    end

    // Hold state, configuration and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
            min_samples_reg     <= MIN_SAMPLES_RST;
            stable_window_reg   <= STABLE_WINDOW_RST;
            rapid_fall_reg      <= RAPID_FALL_RST;
            large_change_reg    <= LARGE_CHANGE_RST;
            ws_reg              <= '0;
            count_reg           <= '0;
            next_time_reg       <= '0;
            first_pending_reg   <= 1'b1;
            m_valid_reg         <= 1'b0;
            m_tdata_reg         <= '0;
            m_tuser_reg         <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            ws_reg            <= ws_next;
            count_reg         <= count_next;
            next_time_reg     <= next_time_next;
            first_pending_reg <= first_pending_next;
            m_valid_reg       <= m_valid_next;
            if (fin_load)
            begin
                m_tdata_reg <= {(OUT_TDATA_W - RATE_W - LABEL_W)'(0), label, rate};
                m_tuser_reg <= kind;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data[INTV_W-1:0];
                    CFG_MIN_SAMPLES:     min_samples_reg     <= cfg_data[MINS_W-1:0];
                    CFG_STABLE_WINDOW:   stable_window_reg   <= cfg_data[WIN_W-1:0];
                    CFG_RAPID_FALL:      rapid_fall_reg      <= cfg_data[THR_W-1:0];
                    CFG_LARGE_CHANGE:    large_change_reg    <= cfg_data[THR_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // Difference against the oldest reading
    assign old_p  = fwd_reg ? p_reg : mem_rdata;
    assign cnt_m1 = count_reg - 1'b1;

    // Advance the item datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            p_reg        <= s_axis_tdata[PRESS_W-1:0];
            now_reg      <= s_axis_tdata[PRESS_W +: TIME_W];
            valid_in_reg <= s_axis_tuser[0];
        end
        if (state_reg == S_UPDATE)
        begin
            enable_reg <= enable_next;
            fwd_reg    <= fwd_next;
        end
        if (state_reg == S_DIFF)
        begin
            pos_reg <= (p_reg > old_p);
            neg_reg <= (p_reg < old_p);
            mag_reg <= (p_reg > old_p) ? p_reg - old_p : old_p - p_reg;
            w_reg   <= W_W'(cnt_m1) * W_W'(sample_interval_reg);
        end
        if (state_reg == S_MUL)
        begin
            num_mag_reg  <= NUM_W'(mag_reg) * NUM_W'(RATE_BASIS_MS);
            tw_rapid_reg <= TW_W'(rapid_fall_reg) * TW_W'(w_reg);
            tw_large_reg <= TW_W'(large_change_reg) * TW_W'(w_reg);
            tw_band_reg  <= TW_W'(STABLE_BAND_PA) * TW_W'(w_reg);
            early_reg    <= (EWC_W'(w_reg) < EWC_W'(stable_window_reg));
            wz_reg       <= (w_reg == '0);
        end
        if (state_reg == S_CMP)
        begin
            ge_rapid_reg <= (MGC_W'(num_mag_reg) >= MGC_W'(tw_rapid_reg));
            ge_large_reg <= (MGC_W'(num_mag_reg) >= MGC_W'(tw_large_reg));
            ge_band_reg  <= (MGC_W'(num_mag_reg) >= MGC_W'(tw_band_reg));
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH))
        else $error("stored count beyond history depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg <= AW'(HISTORY_DEPTH - 1))
        else $error("write slot beyond history depth");

    a_unknown_rate: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_UNKNOWN |-> m_axis_tdata[RATE_W-1:0] == '0)
        else $error("unknown kind with nonzero rate");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside of the divide step");

    a_first_store: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_pending_reg) |-> count_reg == CW'(1))
        else $error("first reading did not leave exactly one stored entry");
`endif

endmodule
